[sv/rtc_pca_pkg.sv]
package rtc_pca_pkg;

    // Default width of the prescaler and divider.
    localparam int unsigned DIVIDER_BITS_DEF = 20;

    // Prescaler value after reset, before masking to the divider width.
    localparam logic [31:0] PRESCALE_RESET = 32'd32767;

    // Alarm value after reset.
    localparam logic [31:0] ALARM_RESET = 32'hFFFF_FFFF;

    // Command carried in tuser.
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } cmd_t;

    // Register map.
    localparam logic [3:0] REG_CRH  = 4'd0;
    localparam logic [3:0] REG_CRL  = 4'd1;
    localparam logic [3:0] REG_PRLH = 4'd2;
    localparam logic [3:0] REG_PRLL = 4'd3;
    localparam logic [3:0] REG_DIVH = 4'd4;
    localparam logic [3:0] REG_DIVL = 4'd5;
    localparam logic [3:0] REG_CNTH = 4'd6;
    localparam logic [3:0] REG_CNTL = 4'd7;
    localparam logic [3:0] REG_ALRH = 4'd8;
    localparam logic [3:0] REG_ALRL = 4'd9;

    // Bit positions of the status flags and interrupt enables.
    localparam int unsigned FLAG_SEC  = 0;
    localparam int unsigned FLAG_ALR  = 1;
    localparam int unsigned FLAG_OVF  = 2;
    localparam int unsigned FLAG_SYNC = 3;

    // Control register low half: config mode and write-busy bit positions.
    localparam int unsigned CRL_CNF  = 4;
    localparam int unsigned CRL_BUSY = 5;

endpackage

[sv/rtc_prescaled_counter_alarm_top.sv]
// Real-time clock with prescaler, 32-bit seconds counter and alarm, driven
// through a stream interface. Every input item is one of three commands,
// carried in s_tuser: a clock tick, a read of one 16-bit register or a write
// of one 16-bit register. The register index and write data travel in s_tdata.
//
// Every accepted item produces exactly one result item on the master side,
// holding the read data (zero for anything other than a read) and the two
// interrupt lines as they stand after that item has taken effect.
//
// Throughput is one item per clock cycle while the receiver does not stall.
// The clock state registers and the result register are both loaded at the
// edge that accepts the item, so the whole update is a single pass of logic
// from the state registers back into themselves.
//
// When the receiver stalls, the result stays in the output register and
// s_tready drops until it is taken; s_tready is high whenever the output
// register is empty or is being emptied in the same cycle.
//
// Reset (aresetn low at a rising edge) clears the divider, counter, flags,
// config mode and enables, loads the prescaler with 32767 and the alarm with
// all ones, and empties the output register.
module rtc_prescaled_counter_alarm_top #(
    parameter int unsigned DIVIDER_BITS = rtc_pca_pkg::DIVIDER_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [3:0] reg_index, [19:4] write_data, [23:20] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [15:0] read_data, [16] irq_global, [17] irq_alarm,
                                   // [23:18] zero
);

    // Clock state.
    logic [DIVIDER_BITS-1:0] div_reg, div_next;
    logic [DIVIDER_BITS-1:0] presc_reg, presc_next;
    logic [31:0]             cnt_reg, cnt_next;
    logic [31:0]             alarm_reg, alarm_next;
    logic [3:0]              flags_reg, flags_next;
    logic                    cnf_reg, cnf_next;
    logic [2:0]              irq_en_reg, irq_en_next;

    // Output register.
    logic        m_valid_reg;
    logic [15:0] rdata_reg;
    logic        irq_global_reg;
    logic        irq_alarm_reg;

    // Decoded input item.
    rtc_pca_pkg::cmd_t cmd;
    logic [3:0]        reg_index;
    logic [15:0]       write_data;
    logic              accept;

    // Values computed for the result.
    logic [15:0] rdata;
    logic        irq_global;
    logic        irq_alarm;

    // Wide views of the divider and prescaler so the halves can be sliced at
    // any divider width.
    logic [31:0] div_wide;
    logic [31:0] presc_wide;
    logic [31:0] cnt_inc;

    assign cmd        = rtc_pca_pkg::cmd_t'(s_tuser[1:0]);
    assign reg_index  = s_tdata[3:0];
    assign write_data = s_tdata[19:4];

    // The output register frees itself when its item is taken, so a new item
    // may enter in the same cycle.
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign div_wide   = 32'(div_reg);
    assign presc_wide = 32'(presc_reg);
    assign cnt_inc    = cnt_reg + 32'd1;

    // Next state and read data for the item at the input.
    always_comb begin
        div_next    = div_reg;
        presc_next  = presc_reg;
        cnt_next    = cnt_reg;
        alarm_next  = alarm_reg;
        flags_next  = flags_reg;
        cnf_next    = cnf_reg;
        irq_en_next = irq_en_reg;
        rdata       = 16'd0;

        case (cmd)
            rtc_pca_pkg::CMD_TICK: begin
                // A divider already at zero reloads and marks one second.
                if (div_reg == '0) begin
                    div_next = presc_reg;
                    cnt_next = cnt_inc;
                    flags_next[rtc_pca_pkg::FLAG_SEC] = 1'b1;
                    if (cnt_inc == 32'd0) begin
                        flags_next[rtc_pca_pkg::FLAG_OVF] = 1'b1;
                    end
                    if (cnt_inc == alarm_reg) begin
                        flags_next[rtc_pca_pkg::FLAG_ALR] = 1'b1;
                    end
                end else begin
                    div_next = div_reg - 1'b1;
                end
                flags_next[rtc_pca_pkg::FLAG_SYNC] = 1'b1;
            end
            rtc_pca_pkg::CMD_READ: begin
                unique case (reg_index)
                    rtc_pca_pkg::REG_CRH:  rdata = {13'd0, irq_en_reg};
                    rtc_pca_pkg::REG_CRL:  rdata = {10'd0, 1'b1, cnf_reg, flags_reg};
                    rtc_pca_pkg::REG_DIVH: rdata = div_wide[31:16];
                    rtc_pca_pkg::REG_DIVL: rdata = div_wide[15:0];
                    rtc_pca_pkg::REG_CNTH: rdata = cnt_reg[31:16];
                    rtc_pca_pkg::REG_CNTL: rdata = cnt_reg[15:0];
                    default:               rdata = 16'd0;
                endcase
            end
            rtc_pca_pkg::CMD_WRITE: begin
                unique case (reg_index)
                    rtc_pca_pkg::REG_CRH: begin
                        irq_en_next = write_data[2:0];
                    end
                    rtc_pca_pkg::REG_CRL: begin
                        // Writing a zero clears a flag; a one leaves it.
                        flags_next = flags_reg & write_data[3:0];
                        cnf_next   = write_data[rtc_pca_pkg::CRL_CNF];
                    end
                    rtc_pca_pkg::REG_PRLH: begin
                        if (cnf_reg) begin
                            presc_next = DIVIDER_BITS'({write_data, presc_wide[15:0]});
                        end
                    end
                    rtc_pca_pkg::REG_PRLL: begin
                        if (cnf_reg) begin
                            presc_next = DIVIDER_BITS'({presc_wide[31:16], write_data});
                        end
                    end
                    rtc_pca_pkg::REG_CNTH: begin
                        if (cnf_reg) begin
                            cnt_next = {write_data, cnt_reg[15:0]};
                        end
                    end
                    rtc_pca_pkg::REG_CNTL: begin
                        if (cnf_reg) begin
                            cnt_next = {cnt_reg[31:16], write_data};
                        end
                    end
                    rtc_pca_pkg::REG_ALRH: begin
                        if (cnf_reg) begin
                            alarm_next = {write_data, alarm_reg[15:0]};
                        end
                    end
                    rtc_pca_pkg::REG_ALRL: begin
                        if (cnf_reg) begin
                            alarm_next = {alarm_reg[31:16], write_data};
                        end
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

    // Interrupt lines reflect the state after the item.
    assign irq_global = (flags_next[rtc_pca_pkg::FLAG_SEC] & irq_en_next[rtc_pca_pkg::FLAG_SEC])
                      | (flags_next[rtc_pca_pkg::FLAG_OVF] & irq_en_next[rtc_pca_pkg::FLAG_OVF]);
    assign irq_alarm  = flags_next[rtc_pca_pkg::FLAG_ALR] & irq_en_next[rtc_pca_pkg::FLAG_ALR];

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_reg    <= '0;
            presc_reg  <= DIVIDER_BITS'(rtc_pca_pkg::PRESCALE_RESET);
            cnt_reg    <= 32'd0;
            alarm_reg  <= rtc_pca_pkg::ALARM_RESET;
            flags_reg  <= 4'd0;
            cnf_reg    <= 1'b0;
            irq_en_reg <= 3'd0;
        end else if (accept) begin
            div_reg    <= div_next;
            presc_reg  <= presc_next;
            cnt_reg    <= cnt_next;
            alarm_reg  <= alarm_next;
            flags_reg  <= flags_next;
            cnf_reg    <= cnf_next;
            irq_en_reg <= irq_en_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rdata_reg      <= rdata;
            irq_global_reg <= irq_global;
            irq_alarm_reg  <= irq_alarm;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, irq_alarm_reg, irq_global_reg, rdata_reg};

    // A tick always leaves the sync flag set.
    a_tick_sets_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd == rtc_pca_pkg::CMD_TICK |=> flags_reg[rtc_pca_pkg::FLAG_SYNC])
        else $error("sync flag not set after a tick");

    // A running divider steps down by one on a tick.
    a_div_step: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd == rtc_pca_pkg::CMD_TICK && div_reg != '0
        |=> div_reg == $past(div_reg) - 1'b1)
        else $error("divider did not count down");

    // The write-busy bit reads back as one in every read of the control register low half.
    a_busy_reads_one: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd == rtc_pca_pkg::CMD_READ && reg_index == rtc_pca_pkg::REG_CRL
        |=> m_tdata[rtc_pca_pkg::CRL_BUSY])
        else $error("write-busy bit read as zero");

    // Without an accepted item the counter holds.
    a_cnt_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(cnt_reg))
        else $error("counter changed without an item");

endmodule
